// ===== rtl/sst_pkg.sv =====
`default_nettype none
package sst_pkg;

  // Table geometry
  localparam int NUM_BLOCKS = 2;
  localparam int SLOT_COUNT = NUM_BLOCKS * 64;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  // Field widths on the channels
  localparam int OP_W    = 3;
  localparam int ID_W    = 64;
  localparam int INDEX_W = 7;
  localparam int COUNT_W = 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_FIND   = 3'd0;
  localparam logic [OP_W-1:0] OP_CREATE = 3'd1;
  localparam logic [OP_W-1:0] OP_MARK   = 3'd2;
  localparam logic [OP_W-1:0] OP_SWEEP  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  // Lowest matching slot found by the id scan
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } sst_match_t;

endpackage
`default_nettype wire

// ===== rtl/sst_if.sv =====
`default_nettype none
// Request channel: one table operation per word
interface sst_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        operation;
  logic signed [63:0] flow_id;

  modport source (output valid, output operation, output flow_id, input ready);
  modport sink   (input valid, input operation, input flow_id, output ready);
endinterface

// Result channel: one result word per operation
interface sst_out_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic       created;
  logic       table_full;
  logic [6:0] slot_index;
  logic [7:0] closed_count;
  logic [7:0] live_count;

  modport source (output valid, output hit, output created, output table_full,
                  output slot_index, output closed_count, output live_count,
                  input ready);
  modport sink   (input valid, input hit, input created, input table_full,
                  input slot_index, input closed_count, input live_count,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/stream_slot_table_core.sv =====
`default_nettype none
// Stream slot table: SLOT_COUNT (128 by default) slots, each with an active bit,
// a delete mark and a 64-bit stream id. Every request word (find, find-or-create,
// mark-delete, sweep marked, clear all) yields exactly one result word. Each
// operation walks the whole table one slot per cycle through the single read
// port of the id memory, then passes the drain and finish states, so a request
// occupies the block from acceptance until the next word can be taken;
// in_ch.ready is high only between operations. A finished result sits in
// an output register, so the next request may be accepted while it waits.
// Unused operation codes change nothing and report only the live count.
module stream_slot_table_core (
  input  logic     clk,
  input  logic     rst_n,
  sst_in_if.sink   in_ch,
  sst_out_if.source out_ch
);
  import sst_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  logic [1:0]            state_r;
  logic [OP_W-1:0]       op_r;
  logic [ID_W-1:0]       id_r;
  logic [IDX_W-1:0]      cnt_r;
  logic                  free_found_r;
  logic [IDX_W-1:0]      free_idx_r;
  logic [CNT_W-1:0]      closed_r;
  logic [CNT_W-1:0]      live_r;
  logic [SLOT_COUNT-1:0] act_r;
  logic [SLOT_COUNT-1:0] mark_r;

  logic                  out_valid_r;
  logic                  out_hit_r;
  logic                  out_created_r;
  logic                  out_full_r;
  logic [INDEX_W-1:0]    out_index_r;
  logic [COUNT_W-1:0]    out_closed_r;
  logic [COUNT_W-1:0]    out_live_r;

  logic                  in_fire;
  logic                  finish_fire;
  logic                  cur_act;
  logic                  cur_mark;
  logic                  cur_free;
  logic                  free_op;
  logic                  do_create;
  logic                  do_mark;
  sst_match_t            match;

  logic                  res_hit;
  logic                  res_created;
  logic                  res_full;
  logic [IDX_W-1:0]      res_idx;
  logic [CNT_W-1:0]      res_closed;
  logic [CNT_W-1:0]      res_live;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign finish_fire = (state_r == ST_FINISH) && (!out_valid_r || out_ch.ready);

  // slot under the scan pointer
  assign cur_act  = act_r[cnt_r];
  assign cur_mark = mark_r[cnt_r];
  assign free_op  = (op_r == OP_SWEEP) || (op_r == OP_CLEAR);
  assign cur_free = (op_r == OP_SWEEP) ? cur_mark :
                    (op_r == OP_CLEAR) ? cur_act  : 1'b0;

  // id scan unit
  sst_id_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_fire),
    .rd_en     (state_r == ST_SCAN),
    .rd_addr   (cnt_r),
    .rd_active (cur_act),
    .key       (id_r),
    .wr_en     (finish_fire && do_create),
    .wr_addr   (free_idx_r),
    .wr_data   (id_r),
    .match     (match)
  );

  // result of the finished scan
  always_comb begin
    res_hit     = 1'b0;
    res_created = 1'b0;
    res_full    = 1'b0;
    res_idx     = '0;
    res_closed  = '0;
    res_live    = live_r;
    do_create   = 1'b0;
    do_mark     = 1'b0;
    case (op_r)
      OP_FIND, OP_MARK: begin
        res_hit = match.vld;
        res_idx = match.vld ? match.idx : '0;
        do_mark = match.vld && (op_r == OP_MARK);
      end
      OP_CREATE: begin
        if (match.vld) begin
          res_hit = 1'b1;
          res_idx = match.idx;
        end else if (free_found_r) begin
          res_hit     = 1'b1;
          res_created = 1'b1;
          res_idx     = free_idx_r;
          res_live    = live_r + CNT_W'(1);
          do_create   = 1'b1;
        end else begin
          res_full = 1'b1;
        end
      end
      OP_SWEEP, OP_CLEAR: begin
        res_closed = closed_r;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE:   if (in_fire) state_r <= ST_SCAN;
        ST_SCAN:   if (cnt_r == LAST_IDX) state_r <= ST_DRAIN;
        ST_DRAIN:  state_r <= ST_FINISH;
        ST_FINISH: if (finish_fire) state_r <= ST_IDLE;
        default:   state_r <= ST_IDLE;
      endcase
    end
  end

  // request capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r         <= in_ch.operation;
      id_r         <= in_ch.flow_id;
      cnt_r        <= '0;
      free_found_r <= 1'b0;
      closed_r     <= '0;
    end else if (state_r == ST_SCAN) begin
      cnt_r <= cnt_r + IDX_W'(1);
      if (!cur_act && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cnt_r;
      end
      if (cur_free) begin
        closed_r <= closed_r + CNT_W'(1);
      end
    end
  end

  // slot flags and live count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= '0;
      mark_r <= '0;
      live_r <= '0;
    end else if (state_r == ST_SCAN && cur_free) begin
      act_r[cnt_r]  <= 1'b0;
      mark_r[cnt_r] <= 1'b0;
      live_r        <= live_r - CNT_W'(1);
    end else if (finish_fire) begin
      if (do_create) begin
        act_r[free_idx_r]  <= 1'b1;
        mark_r[free_idx_r] <= 1'b0;
      end
      if (do_mark) begin
        mark_r[match.idx] <= 1'b1;
      end
      live_r <= res_live;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (finish_fire) begin
      out_hit_r     <= res_hit;
      out_created_r <= res_created;
      out_full_r    <= res_full;
      out_index_r   <= INDEX_W'(res_idx);
      out_closed_r  <= COUNT_W'(res_closed);
      out_live_r    <= COUNT_W'(res_live);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit          = out_hit_r;
  assign out_ch.created      = out_created_r;
  assign out_ch.table_full   = out_full_r;
  assign out_ch.slot_index   = out_index_r;
  assign out_ch.closed_count = out_closed_r;
  assign out_ch.live_count   = out_live_r;

  // checks
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CNT_W'(SLOT_COUNT))
    else $error("live count above table size");

  a_live_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && !free_op) |=> live_r == $past(live_r))
    else $error("live count moved during a lookup scan");

  a_created_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_created_r || out_hit_r) && !(out_full_r && out_hit_r))
    else $error("inconsistent result flags");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("request taken while scan in progress");

endmodule
`default_nettype wire

// ===== rtl/sst_id_match.sv =====
`default_nettype none
// Stream id store with one registered read port and the shared id comparator.
// Tracks the lowest active slot whose id equals the key during a scan.
module sst_id_match (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         rd_en,
  input  logic [sst_pkg::IDX_W-1:0]    rd_addr,
  input  logic                         rd_active,
  input  logic [sst_pkg::ID_W-1:0]     key,
  input  logic                         wr_en,
  input  logic [sst_pkg::IDX_W-1:0]    wr_addr,
  input  logic [sst_pkg::ID_W-1:0]     wr_data,
  output sst_pkg::sst_match_t          match
);
  import sst_pkg::*;

  logic [ID_W-1:0]  mem [SLOT_COUNT];
  logic [ID_W-1:0]  rd_data_r;
  logic             p_vld_r;
  logic             p_act_r;
  logic [IDX_W-1:0] p_idx_r;
  sst_match_t       match_r;

  // id memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // slot tag travels alongside the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= rd_en;
    end
    p_act_r <= rd_active;
    p_idx_r <= rd_addr;
  end

  // compare stage, keeps the first hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r.vld <= 1'b0;
    end else if (start) begin
      match_r.vld <= 1'b0;
    end else if (p_vld_r && p_act_r && !match_r.vld && rd_data_r == key) begin
      match_r.vld <= 1'b1;
    end
    if (p_vld_r && p_act_r && !match_r.vld && rd_data_r == key) begin
      match_r.idx <= p_idx_r;
    end
  end

  assign match = match_r;

endmodule
`default_nettype wire
